// ===== design/tfps_pkg.sv =====
// Package for the four-peak selector: payload structs, the tagged item that
// passes from the front end to the slot engine, and shared constants.
// No dependencies.
package tfps_pkg;

  localparam int ITEMS_PER_EVENT_DEF = 36;
  localparam int KEPT_SLOTS          = 4;
  localparam int SLOT_W              = 2;
  localparam int QUEUE_DEPTH         = 4;
  localparam int Q_PTR_W             = 2;
  localparam int Q_CNT_W             = 3;

  typedef struct packed {
    logic [15:0] peak_energy;
    logic [23:0] coord_energy_sum;
    logic [5:0]  first_strip;
    logic [5:0]  strip_count;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic [15:0]       out_energy;
    logic [23:0]       out_coord_sum;
    logic [5:0]        out_first_strip;
    logic [5:0]        out_strip_count;
    logic              last_of_event;
  } out_item_t;

  // One kept peak.
  typedef struct packed {
    logic [15:0] energy;
    logic [23:0] coord_sum;
    logic [5:0]  first_strip;
    logic [5:0]  strip_count;
  } slot_t;

  // Item as classified by the front end.
  typedef struct packed {
    in_item_t          data;
    logic              fill;
    logic [SLOT_W-1:0] fill_slot;
    logic              last;
  } tag_item_t;

endpackage

// ===== design/tfps_front.sv =====
// Front end of the four-peak selector: counts items within an event and
// tags each one as fill, compare or last. Depends on tfps_pkg.
module tfps_front #(
  parameter int ITEMS_PER_EVENT = tfps_pkg::ITEMS_PER_EVENT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  tfps_pkg::in_item_t  in_data,
  output tfps_pkg::tag_item_t tag_item
);
  import tfps_pkg::*;

  localparam int CNT_W = (ITEMS_PER_EVENT > 1) ? $clog2(ITEMS_PER_EVENT) : 1;
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(ITEMS_PER_EVENT - 1);

  logic [CNT_W-1:0] item_cnt_r, item_cnt_nxt;
  logic             is_last;

  assign is_last = (item_cnt_r == LAST_POS);

  always_comb begin
    item_cnt_nxt = item_cnt_r;
    if (take) begin
      item_cnt_nxt = is_last ? '0 : item_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_cnt_r <= '0;
    end else begin
      item_cnt_r <= item_cnt_nxt;
    end
  end

  always_comb begin
    tag_item.data      = in_data;
    tag_item.fill      = (32'(item_cnt_r) < KEPT_SLOTS);
    tag_item.fill_slot = item_cnt_r[SLOT_W-1:0];
    tag_item.last      = is_last;
  end

endmodule

// ===== design/tfps_queue.sv =====
// Short queue of tagged items between the front end and the slot engine.
// Depends on tfps_pkg.
module tfps_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  tfps_pkg::tag_item_t wr_item,
  output logic                full,
  output logic                rd_valid,
  input  logic                rd_en,
  output tfps_pkg::tag_item_t rd_item
);
  import tfps_pkg::*;

  tag_item_t            entry_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 do_wr, do_rd;

  assign full     = (count_r == Q_CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = entry_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// ===== design/tfps_back.sv =====
// Slot engine of the four-peak selector: keeps the four slots, replaces the
// weakest one, snapshots the slots at event end and drains them as results.
// Depends on tfps_pkg.
module tfps_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  tfps_pkg::tag_item_t q_item,
  output logic                q_pop,
  output tfps_pkg::out_item_t out_data,
  output logic                empty,
  input  logic                pop
);
  import tfps_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(KEPT_SLOTS - 1);

  slot_t             slot_r [KEPT_SLOTS];
  slot_t             slot_nxt [KEPT_SLOTS];
  slot_t             snap_r [KEPT_SLOTS];
  slot_t             new_slot;
  logic              drain_r;
  logic [SLOT_W-1:0] idx_r;
  logic              out_take, drain_free, take;
  logic [SLOT_W-1:0] min_lo, min_hi, min_idx, wr_idx;
  logic              wr_en;

  assign empty      = !drain_r;
  assign out_take   = pop && drain_r;
  assign drain_free = !drain_r || (out_take && (idx_r == LAST_SLOT));
  assign take       = q_valid && (!q_item.last || drain_free);
  assign q_pop      = take;

  // Minimum search, strict compare so ties keep the lower index.
  always_comb begin
    min_lo  = (slot_r[1].energy < slot_r[0].energy) ? SLOT_W'(1) : SLOT_W'(0);
    min_hi  = (slot_r[3].energy < slot_r[2].energy) ? SLOT_W'(3) : SLOT_W'(2);
    min_idx = (slot_r[min_hi].energy < slot_r[min_lo].energy) ? min_hi : min_lo;
  end

  always_comb begin
    new_slot.energy      = q_item.data.peak_energy;
    new_slot.coord_sum   = q_item.data.coord_energy_sum;
    new_slot.first_strip = q_item.data.first_strip;
    new_slot.strip_count = q_item.data.strip_count;
    if (q_item.fill) begin
      wr_idx = q_item.fill_slot;
      wr_en  = take;
    end else begin
      wr_idx = min_idx;
      wr_en  = take && (slot_r[min_idx].energy < q_item.data.peak_energy);
    end
    for (int i = 0; i < KEPT_SLOTS; i++) begin
      slot_nxt[i] = (wr_en && (wr_idx == SLOT_W'(i))) ? new_slot : slot_r[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < KEPT_SLOTS; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
    if (take && q_item.last) begin
      for (int i = 0; i < KEPT_SLOTS; i++) begin
        snap_r[i] <= slot_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r <= 1'b0;
      idx_r   <= '0;
    end else if (take && q_item.last) begin
      drain_r <= 1'b1;
      idx_r   <= '0;
    end else if (out_take) begin
      if (idx_r == LAST_SLOT) begin
        drain_r <= 1'b0;
      end
      idx_r <= idx_r + 1'b1;
    end
  end

  always_comb begin
    out_data.slot_index      = idx_r;
    out_data.out_energy      = snap_r[idx_r].energy;
    out_data.out_coord_sum   = snap_r[idx_r].coord_sum;
    out_data.out_first_strip = snap_r[idx_r].first_strip;
    out_data.out_strip_count = snap_r[idx_r].strip_count;
    out_data.last_of_event   = (idx_r == LAST_SLOT);
  end

endmodule

// ===== design/top_four_peak_select.sv =====
// Top level of the four-peak selector: front end, item queue and slot engine.
// Depends on tfps_pkg, tfps_front, tfps_queue and tfps_back.
//
//  channel   ports                      moves
//  input     push, full, in_data        one candidate peak per transaction
//  result    empty, pop, out_data       one kept slot per transaction
//
// Takes one candidate per cycle while full is low; the slot engine compares and
// replaces as it pops each item, so sustained rate is one item per clock unless it stalls.
// A candidate reaches the slots by way of the queue: the tagged item is written
// to the queue, then read by the engine and written into a slot register.
// At the end of an event the four slots are copied into a drain buffer and
// offered over four transactions; the engine keeps working on the next event.
// The engine stalls only when a new event ends while the previous drain has
// not been popped out; the four-entry queue then fills and full rises.
// Reset (rst_n low, synchronous) clears the item count, queue and drain.
module top_four_peak_select #(
  parameter int ITEMS_PER_EVENT = tfps_pkg::ITEMS_PER_EVENT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  tfps_pkg::in_item_t  in_data,
  output logic                empty,
  input  logic                pop,
  output tfps_pkg::out_item_t out_data
);
  import tfps_pkg::*;

  tag_item_t tag_item, q_item;
  logic      take, q_valid, q_pop;

  // Accept a transaction only while the queue has room.
  assign take = push && !full;

  tfps_front #(
    .ITEMS_PER_EVENT(ITEMS_PER_EVENT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .in_data  (in_data),
    .tag_item (tag_item)
  );

  tfps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (take),
    .wr_item  (tag_item),
    .full     (full),
    .rd_valid (q_valid),
    .rd_en    (q_pop),
    .rd_item  (q_item)
  );

  tfps_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_data (out_data),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

// ===== design/tfps_checker.sv =====
// Port-level checks for the four-peak selector, bound to the top level.
// Depends on tfps_pkg and top_four_peak_select.
module tfps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                empty,
  input logic                pop,
  input tfps_pkg::out_item_t out_data
);
  import tfps_pkg::*;

  // Reset drops any pending results.
  a_reset_empty : assert property (@(posedge clk) !rst_n |=> empty)
    else $error("results pending after reset");

  // Results of an event come in slot order without gaps.
  a_slot_order : assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !out_data.last_of_event) |=>
      (!empty && (out_data.slot_index == $past(out_data.slot_index) + 1'b1)))
    else $error("slot order broken within an event");

  // Only the final slot carries the end-of-event mark.
  a_last_mark : assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.last_of_event == (out_data.slot_index == SLOT_W'(KEPT_SLOTS - 1))))
    else $error("end-of-event mark on wrong slot");

  // A waiting result holds until popped.
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result changed");

endmodule

bind top_four_peak_select tfps_checker u_tfps_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);
